// ===== hw/rtl/psd_pkg.sv =====
// ----------------------------------------------------------------------------
// psd_pkg
// Shared widths, constants, types and state codes of the population
// standard deviation unit.
// ----------------------------------------------------------------------------
package psd_pkg;

    localparam int MAX_ITEMS = 256;
    localparam int SCORE_W   = 16;
    localparam int ADDR_W    = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int SUM_W     = SCORE_W + ADDR_W;
    localparam int VAR_W     = 2 * SCORE_W;
    localparam int SQ_W      = VAR_W + ADDR_W;
    localparam int DIV_CNT_W = $clog2(SQ_W);
    localparam int ROOT_W    = VAR_W / 2;
    localparam int RT_CNT_W  = $clog2(ROOT_W);

    localparam logic [CNT_W-1:0]   MAX_CNT       = CNT_W'(MAX_ITEMS);
    localparam logic [SCORE_W-1:0] THRESH_RESET  = SCORE_W'(384);

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SUM,
        ST_MEAN,
        ST_SQ,
        ST_VAR,
        ST_ROOT,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic             start;
        logic [SQ_W-1:0]  dividend;
        logic [CNT_W-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic            done;
        logic [SQ_W-1:0] quotient;
    } t_div_rsp;

    typedef struct packed {
        logic             start;
        logic [VAR_W-1:0] radicand;
    } t_sqrt_req;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } t_sqrt_rsp;

endpackage

// ===== hw/rtl/psd_div.sv =====
// ----------------------------------------------------------------------------
// psd_div
// Restoring divider, one quotient bit per cycle, shared by the mean and
// the variance steps.
// ----------------------------------------------------------------------------
module psd_div (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  psd_pkg::t_div_req i_req,
    output psd_pkg::t_div_rsp o_rsp
);
    import psd_pkg::*;

    logic [CNT_W-1:0]     r_rem;
    logic [SQ_W-1:0]      r_quo;
    logic [CNT_W-1:0]     r_den;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [CNT_W:0]       shifted;
    logic                 ge;
    logic [CNT_W:0]       diff;

    assign shifted = {r_rem, r_quo[SQ_W-1]};
    assign ge      = shifted >= {1'b0, r_den};
    assign diff    = shifted - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(SQ_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_quo <= i_req.dividend;
            r_den <= i_req.divisor;
        end else if (r_busy) begin
            r_rem <= ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
            r_quo <= {r_quo[SQ_W-2:0], ge};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ===== hw/rtl/psd_sqrt.sv =====
// ----------------------------------------------------------------------------
// psd_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module psd_sqrt (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  psd_pkg::t_sqrt_req i_req,
    output psd_pkg::t_sqrt_rsp o_rsp
);
    import psd_pkg::*;

    logic [ROOT_W+1:0]   r_rem;
    logic [ROOT_W-1:0]   r_root;
    logic [VAR_W-1:0]    r_rad;
    logic [RT_CNT_W-1:0] r_cnt;
    logic                r_busy;
    logic                r_done;

    logic [ROOT_W+2:0]   shifted;
    logic [ROOT_W+2:0]   trial;
    logic                ge;
    logic [ROOT_W+2:0]   diff;

    assign shifted = {r_rem[ROOT_W:0], r_rad[VAR_W-1 -: 2]};
    assign trial   = {1'b0, r_root, 2'b01};
    assign ge      = shifted >= trial;
    assign diff    = shifted - trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == RT_CNT_W'(ROOT_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem  <= '0;
            r_root <= '0;
            r_rad  <= i_req.radicand;
        end else if (r_busy) begin
            r_rem  <= ge ? diff[ROOT_W+1:0] : shifted[ROOT_W+1:0];
            r_root <= {r_root[ROOT_W-2:0], ge};
            r_rad  <= {r_rad[VAR_W-3:0], 2'b00};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.root = r_root;

endmodule

// ===== hw/rtl/population_std_deviation_unit.sv =====
// ----------------------------------------------------------------------------
// population_std_deviation_unit
// Collects Q8.8 scores and reports mean, population standard deviation,
// count, a low-spread flag and an overflow flag for each set.
// ----------------------------------------------------------------------------
// Each score transfer is written to a 256-entry score memory. The transfer
// marked last starts the computation and the input is stalled until its
// result has been taken: a sum pass over the n stored scores (one memory
// read per cycle), a division for the mean (40 quotient bits), a
// squared-difference pass (one 16x16 multiply per cycle), a second division
// for the variance and a square root (16 root bits), after which the result
// is offered. The divider is a restoring unit giving one quotient bit per
// cycle. Scores past 256 in a set are dropped and raise the overflow flag; a
// full set of 256 reads back as 256 on the 9-bit count output.
module population_std_deviation_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [psd_pkg::SCORE_W-1:0]   i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic [psd_pkg::SCORE_W-1:0]   i_score,
    input  logic                          i_last_item,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [psd_pkg::CNT_W-1:0]     o_item_total,
    output logic [psd_pkg::SCORE_W-1:0]   o_mean_value,
    output logic [psd_pkg::SCORE_W-1:0]   o_std_dev,
    output logic                          o_below_threshold,
    output logic                          o_overflowed
);
    import psd_pkg::*;

    t_state              r_state;
    t_state              n_state;

    logic [SCORE_W-1:0]  r_thresh;
    logic [SCORE_W-1:0]  r_mem [MAX_ITEMS];
    logic [SCORE_W-1:0]  r_rdata;
    logic [CNT_W-1:0]    r_count;
    logic                r_drop;
    logic [CNT_W-1:0]    r_idx;
    logic                r_p1;
    logic                r_p2;
    logic [SUM_W-1:0]    r_sum;
    logic [SCORE_W-1:0]  r_mean;
    logic [VAR_W-1:0]    r_prod;
    logic [SQ_W-1:0]     r_sq;

    logic [CNT_W-1:0]    r_total;
    logic [SCORE_W-1:0]  r_out_mean;
    logic [SCORE_W-1:0]  r_out_sd;
    logic                r_out_below;
    logic                r_out_ovf;

    logic                in_xfer;
    logic                out_xfer;
    logic                rd_en;
    logic                pass_busy;
    logic [SCORE_W-1:0]  diff;

    t_div_req            div_req;
    t_div_rsp            div_rsp;
    t_sqrt_req           sqrt_req;
    t_sqrt_rsp           sqrt_rsp;

    psd_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (div_req),
        .o_rsp   (div_rsp)
    );

    psd_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (sqrt_req),
        .o_rsp   (sqrt_rsp)
    );

    assign o_stall  = (r_state != ST_LOAD);
    assign o_valid  = (r_state == ST_OUT);
    assign in_xfer  = i_valid && !o_stall;
    assign out_xfer = o_valid && !i_stall;

    assign rd_en     = ((r_state == ST_SUM) || (r_state == ST_SQ)) && (r_idx < r_count);
    assign pass_busy = rd_en || r_p1 || r_p2;
    assign diff      = (r_rdata >= r_mean) ? (r_rdata - r_mean) : (r_mean - r_rdata);

    // sequencer
    always_comb begin
        n_state           = r_state;
        div_req.start     = 1'b0;
        div_req.dividend  = {{(SQ_W - SUM_W){1'b0}}, r_sum};
        div_req.divisor   = r_count;
        sqrt_req.start    = 1'b0;
        sqrt_req.radicand = div_rsp.quotient[VAR_W-1:0];
        case (r_state)
            ST_LOAD: begin
                if (in_xfer && i_last_item) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: begin
                if (!rd_en && !r_p1) begin
                    div_req.start = 1'b1;
                    n_state       = ST_MEAN;
                end
            end
            ST_MEAN: begin
                if (div_rsp.done) begin
                    n_state = ST_SQ;
                end
            end
            ST_SQ: begin
                div_req.dividend = r_sq;
                if (!pass_busy) begin
                    div_req.start = 1'b1;
                    n_state       = ST_VAR;
                end
            end
            ST_VAR: begin
                if (div_rsp.done) begin
                    sqrt_req.start = 1'b1;
                    n_state        = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (sqrt_rsp.done) begin
                    n_state = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_xfer) begin
                    n_state = ST_LOAD;
                end
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RESET;
            r_count  <= '0;
            r_drop   <= 1'b0;
            r_idx    <= '0;
            r_p1     <= 1'b0;
            r_p2     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thresh <= i_cfg_data;
            end
            r_p1 <= rd_en;
            r_p2 <= r_p1;
            if (in_xfer) begin
                if (r_count < MAX_CNT) begin
                    r_count <= r_count + 1'b1;
                end else begin
                    r_drop <= 1'b1;
                end
                r_idx <= '0;
            end else if (rd_en) begin
                r_idx <= r_idx + 1'b1;
            end else if ((r_state == ST_MEAN) && div_rsp.done) begin
                r_idx <= '0;
            end
            if ((r_state == ST_ROOT) && sqrt_rsp.done) begin
                r_count <= '0;
                r_drop  <= 1'b0;
                r_idx   <= '0;
            end
        end
    end

    // score memory
    always_ff @(posedge i_clk) begin
        if (in_xfer && (r_count < MAX_CNT)) begin
            r_mem[r_count[ADDR_W-1:0]] <= i_score;
        end
        if (rd_en) begin
            r_rdata <= r_mem[r_idx[ADDR_W-1:0]];
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_sum <= '0;
        end else if ((r_state == ST_SUM) && r_p1) begin
            r_sum <= r_sum + {{(SUM_W - SCORE_W){1'b0}}, r_rdata};
        end
        if ((r_state == ST_MEAN) && div_rsp.done) begin
            r_mean <= div_rsp.quotient[SCORE_W-1:0];
            r_sq   <= '0;
        end else if ((r_state == ST_SQ) && r_p2) begin
            r_sq <= r_sq + {{(SQ_W - VAR_W){1'b0}}, r_prod};
        end
        if (r_p1) begin
            r_prod <= diff * diff;
        end
        if ((r_state == ST_ROOT) && sqrt_rsp.done) begin
            r_total     <= r_count;
            r_out_mean  <= r_mean;
            r_out_sd    <= sqrt_rsp.root;
            r_out_below <= sqrt_rsp.root < r_thresh;
            r_out_ovf   <= r_drop;
        end
    end

    assign o_item_total      = r_total;
    assign o_mean_value      = r_out_mean;
    assign o_std_dev         = r_out_sd;
    assign o_below_threshold = r_out_below;
    assign o_overflowed      = r_out_ovf;

    // checks
    ap_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= MAX_CNT)
        else $error("score count above capacity");

    ap_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_idx <= r_count)
        else $error("read index past stored count");

    ap_no_load_while_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_stall)
        else $error("input open while a result is pending");

    ap_clear_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_xfer |=> (r_count == '0) && !r_drop)
        else $error("set state not cleared after result transfer");

endmodule
